/* rtl/four_lane_xoroshiro128plus_prng_assert.svh */
// Assertion macros for the four-lane xoroshiro128+ block.
`ifndef FOUR_LANE_XOROSHIRO128PLUS_PRNG_ASSERT_SVH
`define FOUR_LANE_XOROSHIRO128PLUS_PRNG_ASSERT_SVH

// Concurrent assertion on a named clock and active-low reset.
`define FLXP_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on clk_i and rst_ni.
`define FLXP_ASSERT(label, prop, msg) \
  `FLXP_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

/* rtl/flxp_pkg.sv */
`timescale 1ns / 1ps

package flxp_pkg;

  localparam int unsigned LANES   = 4;
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned HALF_W  = WORD_W / 2;

  // xoroshiro128+ step
  localparam int unsigned ROT_A   = 24;
  localparam int unsigned SHIFT_B = 16;
  localparam int unsigned ROT_C   = 37;

  // splitmix64
  localparam logic [WORD_W-1:0] SM_GAMMA = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [WORD_W-1:0] SM_MUL1  = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [WORD_W-1:0] SM_MUL2  = 64'h94D0_49BB_1331_11EB;
  localparam int unsigned SM_SH0  = 30;
  localparam int unsigned SM_SH1  = 27;
  localparam int unsigned SM_SH2  = 31;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_SEED_ADD,
    ST_SEED_M0,
    ST_SEED_M1,
    ST_SEED_M2,
    ST_SEED_MIX,
    ST_DONE
  } flxp_state_e;

  typedef logic [WORD_W-1:0] word_t;

endpackage

/* rtl/flxp_if.sv */
`timescale 1ns / 1ps

interface flxp_req_if import flxp_pkg::*;;
  logic  valid;
  logic  ready;
  logic  cmd;
  word_t seed_value;

  modport source (output valid, output cmd, output seed_value, input ready);
  modport sink   (input valid, input cmd, input seed_value, output ready);
endinterface

interface flxp_rsp_if import flxp_pkg::*;;
  logic  valid;
  logic  ready;
  word_t random_value;

  modport source (output valid, output random_value, input ready);
  modport sink   (input valid, input random_value, output ready);
endinterface

/* rtl/four_lane_xoroshiro128plus_prng.sv */
`timescale 1ns / 1ps
// Draw at lane index 0..2: the latched sum of that lane goes through the result register, no lane is stepped.
// Draw at lane index 3: one lane stepped per cycle through one shared step unit, lane 3's sum is the result.
// Reseed: eight splitmix64 words on one shared 32x32 multiplier, no result.
// One request in flight; a result may wait in the output register while the next is taken.
// Reset (async, active low): lanes and sum latch cleared, lane index 3.
module four_lane_xoroshiro128plus_prng import flxp_pkg::*; #(
  parameter int unsigned Lanes = LANES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  flxp_req_if.sink    req_i,
  flxp_rsp_if.source  rsp_o
);

  localparam int unsigned LaneW = $clog2(Lanes);
  localparam int unsigned CntW  = $clog2(2 * Lanes);

  flxp_state_e state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [LaneW-1:0] idx_q, idx_d;
  logic             rnd_q, rnd_d;
  word_t            s0_q [Lanes];
  word_t            s0_d [Lanes];
  word_t            s1_q [Lanes];
  word_t            s1_d [Lanes];
  word_t            sum_q [Lanes];
  word_t            sum_d [Lanes];
  word_t            st_q, st_d;
  word_t            z_q, z_d;
  word_t            acc_q, acc_d;
  word_t            res_q, res_d;
  word_t            od_q, od_d;
  logic             ov_q, ov_d;

  logic [LaneW-1:0]  lane;
  logic [LaneW-1:0]  seed_lane;
  word_t             cur_s0, cur_s1, lane_sum, lane_x, new_s0, new_s1;
  word_t             st_next, mix_c, seed_word;
  logic [HALF_W-1:0] mul_a, mul_b;
  word_t             prod;

  assign lane      = cnt_q[LaneW-1:0];
  assign seed_lane = LaneW'(Lanes - 1) - cnt_q[LaneW-1:0];

  // shared lane step unit
  assign cur_s0   = s0_q[lane];
  assign cur_s1   = s1_q[lane];
  assign lane_sum = cur_s0 + cur_s1;
  assign lane_x   = cur_s0 ^ cur_s1;
  assign new_s0   = ((cur_s0 << ROT_A) | (cur_s0 >> (WORD_W - ROT_A)))
                    ^ lane_x ^ (lane_x << SHIFT_B);
  assign new_s1   = (lane_x << ROT_C) | (lane_x >> (WORD_W - ROT_C));

  // splitmix64 datapath, one 32x32 multiplier
  assign st_next   = st_q + SM_GAMMA;
  assign mix_c     = rnd_q ? SM_MUL2 : SM_MUL1;
  assign seed_word = acc_q ^ (acc_q >> SM_SH2);

  always_comb begin
    mul_a = z_q[HALF_W-1:0];
    mul_b = mix_c[HALF_W-1:0];
    if (state_q == ST_SEED_M1) begin
      mul_b = mix_c[WORD_W-1:HALF_W];
    end else if (state_q == ST_SEED_M2) begin
      mul_a = z_q[WORD_W-1:HALF_W];
    end
  end

  assign prod = WORD_W'(mul_a) * WORD_W'(mul_b);

  assign req_i.ready        = (state_q == ST_IDLE);
  assign rsp_o.valid        = ov_q;
  assign rsp_o.random_value = od_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    rnd_d   = rnd_q;
    s0_d    = s0_q;
    s1_d    = s1_q;
    sum_d   = sum_q;
    st_d    = st_q;
    z_d     = z_q;
    acc_d   = acc_q;
    res_d   = res_q;
    od_d    = od_q;
    ov_d    = ov_q;
    if (ov_q && rsp_o.ready) begin
      ov_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          if (req_i.cmd) begin
            st_d    = req_i.seed_value;
            cnt_d   = '0;
            rnd_d   = 1'b0;
            idx_d   = LaneW'(Lanes - 1);
            state_d = ST_SEED_ADD;
          end else if (idx_q == LaneW'(Lanes - 1)) begin
            cnt_d   = '0;
            state_d = ST_STEP;
          end else begin
            res_d   = sum_q[idx_q];
            idx_d   = idx_q + 1'b1;
            state_d = ST_DONE;
          end
        end
      end
      ST_STEP: begin
        sum_d[lane] = lane_sum;
        s0_d[lane]  = new_s0;
        s1_d[lane]  = new_s1;
        if (lane == LaneW'(Lanes - 1)) begin
          res_d   = lane_sum;
          idx_d   = '0;
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_SEED_ADD: begin
        st_d    = st_next;
        z_d     = st_next ^ (st_next >> SM_SH0);
        state_d = ST_SEED_M0;
      end
      ST_SEED_M0: begin
        acc_d   = prod;
        state_d = ST_SEED_M1;
      end
      ST_SEED_M1: begin
        acc_d   = {acc_q[WORD_W-1:HALF_W] + prod[HALF_W-1:0], acc_q[HALF_W-1:0]};
        state_d = ST_SEED_M2;
      end
      ST_SEED_M2: begin
        acc_d   = {acc_q[WORD_W-1:HALF_W] + prod[HALF_W-1:0], acc_q[HALF_W-1:0]};
        state_d = ST_SEED_MIX;
      end
      ST_SEED_MIX: begin
        if (!rnd_q) begin
          z_d     = acc_q ^ (acc_q >> SM_SH1);
          rnd_d   = 1'b1;
          state_d = ST_SEED_M0;
        end else begin
          if (cnt_q[CntW-1]) begin
            s1_d[seed_lane] = seed_word;
          end else begin
            s0_d[seed_lane] = seed_word;
          end
          rnd_d = 1'b0;
          if (cnt_q == CntW'(2 * Lanes - 1)) begin
            state_d = ST_IDLE;
          end else begin
            cnt_d   = cnt_q + 1'b1;
            state_d = ST_SEED_ADD;
          end
        end
      end
      ST_DONE: begin
        if (!ov_q || rsp_o.ready) begin
          ov_d    = 1'b1;
          od_d    = res_q;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      idx_q   <= LaneW'(Lanes - 1);
      rnd_q   <= 1'b0;
      ov_q    <= 1'b0;
      for (int i = 0; i < Lanes; i++) begin
        s0_q[i]  <= '0;
        s1_q[i]  <= '0;
        sum_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      rnd_q   <= rnd_d;
      ov_q    <= ov_d;
      s0_q    <= s0_d;
      s1_q    <= s1_d;
      sum_q   <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q  <= st_d;
    z_q   <= z_d;
    acc_q <= acc_d;
    res_q <= res_d;
    od_q  <= od_d;
  end

endmodule

/* rtl/flxp_checker.sv */
`timescale 1ns / 1ps
`include "four_lane_xoroshiro128plus_prng_assert.svh"

module flxp_checker import flxp_pkg::*; (
  input logic  clk_i,
  input logic  rst_ni,
  input logic  req_valid_i,
  input logic  req_ready_i,
  input logic  req_cmd_i,
  input logic  rsp_valid_i,
  input logic  rsp_ready_i,
  input word_t rsp_value_i
);

  logic req_acc;
  assign req_acc = req_valid_i && req_ready_i;

  `FLXP_ASSERT(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_value_i), "stalled result changed")
  `FLXP_ASSERT(a_busy_after_req, req_acc |=> !req_ready_i, "request taken while busy")
  `FLXP_ASSERT(a_seed_silent, req_acc && req_cmd_i |=> !$rose(rsp_valid_i), "reseed gave a result")
  `FLXP_ASSERT(a_seed_long, req_acc && req_cmd_i |-> ##4 !req_ready_i, "reseed ended early")

endmodule

bind four_lane_xoroshiro128plus_prng flxp_checker u_flxp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .req_cmd_i   (req_i.cmd),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_value_i (rsp_o.random_value)
);

/* tb/four_lane_xoroshiro128plus_prng_tb.sv */
`timescale 1ns / 1ps

module four_lane_xoroshiro128plus_prng_tb;
  import flxp_pkg::*;

  localparam int unsigned RandomRequests = 1400;
  localparam int unsigned CycleLimit     = 1000000;
  localparam int unsigned DrainCycles    = 100;
  localparam int unsigned MaxPrinted     = 20;

  typedef enum logic {
    CMD_DRAW   = 1'b0,
    CMD_RESEED = 1'b1
  } prng_cmd_e;

  class prng_scoreboard;
    word_t       lane_s0[LANES];
    word_t       lane_s1[LANES];
    word_t       sum_latch[LANES];
    logic [1:0]  lane_idx;
    word_t       expected_words[$];
    int unsigned mismatches;
    int unsigned draws;
    int unsigned reseeds;
    int unsigned words_checked;

    function new();
      for (int i = 0; i < LANES; i++) begin
        lane_s0[i]   = '0;
        lane_s1[i]   = '0;
        sum_latch[i] = '0;
      end
      lane_idx      = 2'd3;
      mismatches    = 0;
      draws         = 0;
      reseeds       = 0;
      words_checked = 0;
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= MaxPrinted) begin
        $display("[%0t] mismatch: %s", $realtime, msg);
      end
    endtask

    function word_t splitmix(inout word_t st);
      word_t z;
      st = st + SM_GAMMA;
      z  = st;
      z  = (z ^ (z >> SM_SH0)) * SM_MUL1;
      z  = (z ^ (z >> SM_SH1)) * SM_MUL2;
      return z ^ (z >> SM_SH2);
    endfunction

    function word_t rotl(word_t x, int unsigned k);
      return (x << k) | (x >> (WORD_W - k));
    endfunction

    function void note_request(prng_cmd_e cmd, word_t seed);
      word_t st;
      word_t a;
      word_t b;
      if (cmd == CMD_RESEED) begin
        reseeds++;
        st = seed;
        for (int i = LANES - 1; i >= 0; i--) lane_s0[i] = splitmix(st);
        for (int i = LANES - 1; i >= 0; i--) lane_s1[i] = splitmix(st);
        lane_idx = 2'd3;
      end else begin
        draws++;
        if (lane_idx != 2'd3) begin
          expected_words.push_back(sum_latch[lane_idx]);
          lane_idx = lane_idx + 2'd1;
        end else begin
          for (int i = 0; i < LANES; i++) begin
            a            = lane_s0[i];
            b            = lane_s1[i];
            sum_latch[i] = a + b;
            b            = b ^ a;
            lane_s0[i]   = rotl(a, ROT_A) ^ b ^ (b << SHIFT_B);
            lane_s1[i]   = rotl(b, ROT_C);
          end
          lane_idx = 2'd0;
          expected_words.push_back(sum_latch[LANES-1]);
        end
      end
    endfunction

    task check_result(word_t got);
      word_t want;
      words_checked++;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word %h", got));
      end else begin
        want = expected_words.pop_front();
        if (got !== want) begin
          report($sformatf("random_value %h, expected %h", got, want));
        end
      end
    endtask
  endclass

  logic           clk_i;
  logic           rst_ni;
  int unsigned    cycle_count;
  int unsigned    burst_left;
  prng_scoreboard sb;

  flxp_req_if req_if ();
  flxp_rsp_if rsp_if ();

  four_lane_xoroshiro128plus_prng u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d words still outstanding", cycle_count,
               sb.expected_words.size());
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      sb.check_result(rsp_if.random_value);
    end
  end

  // receiver: runs of always-ready, random ready, and hard stalls
  initial begin : rsp_stall
    int unsigned mode;
    int unsigned span;
    rsp_if.ready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      span = (mode == 2) ? $urandom_range(1, 12) : $urandom_range(1, 60);
      for (int unsigned k = 0; k < span; k++) begin
        @(posedge clk_i);
        case (mode)
          0: begin
            rsp_if.ready <= 1'b1;
          end
          1: begin
            rsp_if.ready <= 1'($urandom_range(0, 1));
          end
          default: begin
            rsp_if.ready <= 1'b0;
          end
        endcase
      end
    end
  end

  task automatic issue(prng_cmd_e cmd, word_t seed);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    req_if.valid      <= 1'b1;
    req_if.cmd        <= cmd;
    req_if.seed_value <= seed;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(cmd, seed);
  endtask

  initial begin : stimulus
    word_t       seed;
    int unsigned pick;
    sb                = new();
    cycle_count       = 0;
    burst_left        = 0;
    rst_ni            <= 1'b0;
    req_if.valid      <= 1'b0;
    req_if.cmd        <= CMD_DRAW;
    req_if.seed_value <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // draws straight out of reset return zero
    repeat (5) issue(CMD_DRAW, 64'hDEAD_BEEF_0BAD_F00D);
    issue(CMD_RESEED, '0);
    repeat (4) issue(CMD_DRAW, '0);
    issue(CMD_RESEED, '1);
    repeat (2) issue(CMD_DRAW, '0);
    // reseed partway through the latched lanes
    issue(CMD_RESEED, 64'h8000_0000_0000_0001);
    repeat (5) issue(CMD_DRAW, '1);
    issue(CMD_RESEED, 64'hAAAA_AAAA_AAAA_AAAA);
    issue(CMD_RESEED, 64'h5555_5555_5555_5555);
    repeat (3) issue(CMD_DRAW, '0);

    for (int unsigned n = 0; n < RandomRequests; n++) begin
      seed = {$urandom(), $urandom()};
      if ($urandom_range(0, 99) < 8) begin
        pick = $urandom_range(0, 7);
        case (pick)
          0: seed = '0;
          1: seed = '1;
          2: seed = word_t'(1) << $urandom_range(0, WORD_W - 1);
          3: seed = ~(word_t'(1) << $urandom_range(0, WORD_W - 1));
          default: ;
        endcase
        issue(CMD_RESEED, seed);
      end else begin
        issue(CMD_DRAW, seed);
      end
    end
    req_if.valid <= 1'b0;

    while (sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("ran %0d draws and %0d reseeds with random gaps and output stalls",
             sb.draws, sb.reseeds);
    $display("compared %0d words, %0d mismatches", sb.words_checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/flxp_pkg.sv
rtl/flxp_if.sv
rtl/four_lane_xoroshiro128plus_prng.sv
rtl/flxp_checker.sv
tb/four_lane_xoroshiro128plus_prng_tb.sv
